// ----- hw/rtl/gtg_pkg.sv -----
// package: types, constants and tables for the go-to-goal drive controller
package gtg_pkg;

    localparam int CordicStepsDef = 16;
    localparam int CordicStepsMax = 24;

    localparam logic [30:0] PiQ29  = 31'd1686629713;
    localparam logic [29:0] Ln2Q30 = 30'd744261118;
    localparam logic [30:0] OneQ30 = 31'd1073741824;

    localparam logic [2:0] CFG_ARRIVAL_RADIUS = 3'd0;
    localparam logic [2:0] CFG_ANGLE_DEADBAND = 3'd1;
    localparam logic [2:0] CFG_TURN_GAIN      = 3'd2;
    localparam logic [2:0] CFG_MAX_TURN_RATE  = 3'd3;
    localparam logic [2:0] CFG_MAX_ADV_SPEED  = 3'd4;
    localparam logic [2:0] CFG_SPEED_DECAY    = 3'd5;

    typedef struct packed {
        logic [15:0] arrival_radius;
        logic [14:0] angle_deadband;
        logic [7:0]  turn_gain;
        logic [14:0] max_turn_rate;
        logic [11:0] top_speed;
        logic [11:0] speed_decay;
    } t_cfg;

    typedef struct packed {
        logic        new_goal;
        logic [15:0] goal_x;
        logic [15:0] goal_y;
        logic [15:0] robot_x;
        logic [15:0] robot_y;
        logic [15:0] robot_heading;
    } t_in_item;

    typedef struct packed {
        logic [11:0] advance_speed;
        logic [15:0] turn_rate;
        logic        arrived;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;       // take input item, update goal, form deltas
        logic sq_dist;    // form squared distance
        logic cordic_init;
        logic cordic_step;
        logic bearing;
        logic turn_mul;
        logic turn_sat;
        logic exp_mul;
        logic exp_red;    // one range-reduction subtract
        logic exp_term;   // one series term
        logic exp_term_div;
        logic exp_fin_mul;
        logic exp_fin;
        logic arrive;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic goal_active;
        logic near_goal;
        logic cordic_last;
        logic red_done;
        logic n_big;
        logic term_last;
    } t_sts;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // reciprocal of k, exact floor quotient for a 30-bit numerator
    function automatic logic [31:0] recip_mul(input logic [3:0] k);
        logic [31:0] v;
        case (k)
            4'd1:  v = 32'd1073741824;
            4'd2:  v = 32'd1073741824;
            4'd3:  v = 32'd1431655766;
            4'd4:  v = 32'd1073741824;
            4'd5:  v = 32'd1717986919;
            4'd6:  v = 32'd1431655766;
            4'd7:  v = 32'd1227133514;
            4'd8:  v = 32'd1073741824;
            4'd9:  v = 32'd1908874354;
            4'd10: v = 32'd1717986919;
            4'd11: v = 32'd1561806290;
            4'd12: v = 32'd1431655766;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] recip_shift(input logic [3:0] k);
        logic [5:0] v;
        case (k)
            4'd1:  v = 6'd30;
            4'd2:  v = 6'd31;
            4'd3:  v = 6'd32;
            4'd4:  v = 6'd32;
            4'd5:  v = 6'd33;
            4'd6:  v = 6'd33;
            4'd7:  v = 6'd33;
            4'd8:  v = 6'd33;
            default: v = 6'd34;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/gtg_if.sv -----
// valid/ready channel interface
interface gtg_if #(
    parameter int Width = 1
);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/gtg_ctrl.sv -----
// controller state machine sequencing the datapath
module gtg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_res_valid,
    input  logic          i_out_free,
    input  gtg_pkg::t_sts i_sts,
    output gtg_pkg::t_cmd o_cmd
);
    import gtg_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIST  = 4'd1;
    localparam logic [3:0] S_TEST  = 4'd2;
    localparam logic [3:0] S_CORD  = 4'd3;
    localparam logic [3:0] S_BEAR  = 4'd4;
    localparam logic [3:0] S_TMUL  = 4'd5;
    localparam logic [3:0] S_TSAT  = 4'd6;
    localparam logic [3:0] S_EMUL  = 4'd7;
    localparam logic [3:0] S_ERED  = 4'd8;
    localparam logic [3:0] S_ETRM  = 4'd9;
    localparam logic [3:0] S_EDIV  = 4'd10;
    localparam logic [3:0] S_EFM   = 4'd11;
    localparam logic [3:0] S_EFIN  = 4'd12;
    localparam logic [3:0] S_WAIT  = 4'd13;
    localparam logic [3:0] S_CHK   = 4'd14;

    logic [3:0] r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd       = '0;
        o_res_valid = 1'b0;
        n_state     = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                n_state = i_sts.goal_active ? S_DIST : S_IDLE;
            end
            S_DIST: begin
                o_cmd.sq_dist = 1'b1;
                n_state       = S_TEST;
            end
            S_TEST: begin
                if (i_sts.near_goal) begin
                    if (i_out_free) begin
                        o_cmd.arrive = 1'b1;
                        o_res_valid  = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_cmd.cordic_init = 1'b1;
                    n_state           = S_CORD;
                end
            end
            S_CORD: begin
                o_cmd.cordic_step = 1'b1;
                if (i_sts.cordic_last) n_state = S_BEAR;
            end
            S_BEAR: begin
                o_cmd.bearing = 1'b1;
                n_state       = S_TMUL;
            end
            S_TMUL: begin
                o_cmd.turn_mul = 1'b1;
                n_state        = S_TSAT;
            end
            S_TSAT: begin
                o_cmd.turn_sat = 1'b1;
                n_state        = S_EMUL;
            end
            S_EMUL: begin
                o_cmd.exp_mul = 1'b1;
                n_state       = S_ERED;
            end
            S_ERED: begin
                if (i_sts.n_big) begin
                    n_state = S_EFIN;
                end else if (i_sts.red_done) begin
                    n_state = S_ETRM;
                end else begin
                    o_cmd.exp_red = 1'b1;
                end
            end
            S_ETRM: begin
                o_cmd.exp_term = 1'b1;
                n_state        = S_EDIV;
            end
            S_EDIV: begin
                o_cmd.exp_term_div = 1'b1;
                n_state            = i_sts.term_last ? S_EFM : S_ETRM;
            end
            S_EFM: begin
                o_cmd.exp_fin_mul = 1'b1;
                n_state           = S_EFIN;
            end
            S_EFIN: begin
                o_cmd.exp_fin = 1'b1;
                n_state       = S_WAIT;
            end
            S_WAIT: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule

// ----- hw/rtl/gtg_dp.sv -----
// datapath: goal store, distance test, cordic, turn and speed arithmetic
module gtg_dp #(
    parameter int CordicSteps = gtg_pkg::CordicStepsDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gtg_pkg::t_cfg     i_cfg,
    input  gtg_pkg::t_in_item i_item,
    input  gtg_pkg::t_cmd     i_cmd,
    output gtg_pkg::t_sts     o_sts,
    output gtg_pkg::t_out_item o_res
);
    import gtg_pkg::*;

    localparam int StepW = $clog2(CordicSteps + 1);

    // goal state
    logic              r_goal_act;
    logic signed [15:0] r_gx, r_gy;
    logic [15:0]       r_head;
    logic signed [16:0] r_dx, r_dy;
    logic [33:0]       r_d2;
    logic              r_zero;

    // cordic
    logic signed [35:0] r_cx, r_cy;
    logic [31:0]        r_cz;
    logic [StepW-1:0]   r_ci;

    // turn
    logic signed [16:0] r_b;
    logic [16:0]        r_mag;
    logic [55:0]        r_prod;
    logic [14:0]        r_tm;
    logic [24:0]        r_gm;

    // exp
    logic [38:0] r_x30;
    logic [3:0]  r_n;
    logic [30:0] r_term;
    logic [31:0] r_pos, r_neg;
    logic [3:0]  r_k;
    logic [29:0] r_num;
    logic [43:0] r_fin;
    logic [11:0] r_speed;
    logic        r_big;

    logic signed [16:0] rx_s, ry_s;
    logic signed [16:0] ndx, ndy;
    logic               goal_now;
    logic signed [35:0] xs, ys;
    logic [4:0]         ci5;
    logic [15:0]        phi, b16;
    logic [55:0]        tm_rnd;
    logic [14:0]        tm_sat;
    logic [26:0]        x_prod;
    logic [60:0]        tr;
    logic [61:0]        qp;
    logic [29:0]        quo;
    logic [31:0]        sum;

    assign rx_s     = 17'(signed'(i_item.robot_x));
    assign ry_s     = 17'(signed'(i_item.robot_y));
    assign goal_now = i_item.new_goal | r_goal_act;
    assign ndx      = (i_item.new_goal ? 17'(signed'(i_item.goal_x)) : 17'(r_gx)) - rx_s;
    assign ndy      = (i_item.new_goal ? 17'(signed'(i_item.goal_y)) : 17'(r_gy)) - ry_s;
    assign ci5      = 5'(r_ci);
    assign xs       = r_cx >>> r_ci;
    assign ys       = r_cy >>> r_ci;
    assign phi      = 16'((33'(r_cz) + 33'h8000) >> 16);
    assign b16      = 16'h4000 - phi + (r_head + 16'h8000);
    assign tm_rnd   = (r_prod + (56'd1 << 37)) >> 38;
    assign tm_sat   = (tm_rnd > 56'(i_cfg.max_turn_rate)) ? i_cfg.max_turn_rate : 15'(tm_rnd);
    assign x_prod   = 27'(tm_sat) * 27'(i_cfg.speed_decay);
    assign tr       = 61'(r_term) * 61'(r_x30[29:0]);
    assign qp       = 62'(r_num) * 62'(recip_mul(r_k));
    assign quo      = 30'(qp >> recip_shift(r_k));
    assign sum      = (r_pos > r_neg) ? r_pos - r_neg : 32'd0;

    assign o_sts.goal_active = r_goal_act;
    assign o_sts.near_goal   = r_d2 < 34'(32'(i_cfg.arrival_radius) * 32'(i_cfg.arrival_radius));
    assign o_sts.cordic_last = (32'(r_ci) == 32'(CordicSteps - 1));
    assign o_sts.red_done    = r_x30 < 39'(Ln2Q30);
    assign o_sts.n_big       = r_big;
    assign o_sts.term_last   = (r_k == 4'd12);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_act <= 1'b0;
            r_gx       <= '0;
            r_gy       <= '0;
        end else begin
            if (i_cmd.load) begin
                if (i_item.new_goal) begin
                    r_gx <= signed'(i_item.goal_x);
                    r_gy <= signed'(i_item.goal_y);
                end
                r_goal_act <= goal_now;
            end
            if (i_cmd.arrive) r_goal_act <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx   <= ndx;
            r_dy   <= ndy;
            r_head <= i_item.robot_heading;
            r_zero <= (ndx == 17'sd0) && (ndy == 17'sd0);
        end
        if (i_cmd.sq_dist) r_d2 <= (34'(r_dx) * 34'(r_dx)) + (34'(r_dy) * 34'(r_dy));
        if (i_cmd.cordic_init) begin
            r_ci <= '0;
            if (r_dx < 0) begin
                r_cx <= -36'(r_dx);
                r_cy <= -36'(r_dy);
                r_cz <= 32'h80000000;
            end else begin
                r_cx <= 36'(r_dx);
                r_cy <= 36'(r_dy);
                r_cz <= '0;
            end
        end
        if (i_cmd.cordic_step) begin
            r_ci <= r_ci + 1'b1;
            if (r_cy >= 0) begin
                r_cx <= r_cx + ys;
                r_cy <= r_cy - xs;
                r_cz <= r_cz + atan_entry(ci5);
            end else begin
                r_cx <= r_cx - ys;
                r_cy <= r_cy + xs;
                r_cz <= r_cz - atan_entry(ci5);
            end
        end
        if (i_cmd.bearing) begin
            r_b   <= r_zero ? 17'sd0 : 17'(signed'(b16));
            r_mag <= r_zero ? 17'd0 :
                     (b16[15] ? 17'd65536 - 17'(b16) : 17'(b16));
        end
        if (i_cmd.turn_mul) begin
            r_gm <= (r_mag < 17'(i_cfg.angle_deadband)) ? 25'd0 :
                    25'(r_mag) * 25'(i_cfg.turn_gain);
        end
        if (i_cmd.turn_sat) begin
            r_prod <= 56'(r_gm) * 56'(PiQ29);
        end
        if (i_cmd.exp_mul) begin
            r_tm   <= tm_sat;
            r_x30  <= {x_prod, 12'd0};
            r_n    <= '0;
            r_big  <= 1'b0;
            r_term <= OneQ30;
            r_pos  <= 32'(OneQ30);
            r_neg  <= '0;
            r_k    <= '0;
        end
        if (i_cmd.exp_red) begin
            r_x30 <= r_x30 - 39'(Ln2Q30);
            r_n   <= r_n + 1'b1;
            if (r_n == 4'd12) r_big <= 1'b1;
        end
        if (i_cmd.exp_term) begin
            r_num <= 30'(tr >> 30);
            r_k   <= r_k + 1'b1;
        end
        if (i_cmd.exp_term_div) begin
            // divide by k through its reciprocal
            r_term <= 31'(quo);
            if (r_k[0]) r_neg <= r_neg + 32'(quo);
            else        r_pos <= r_pos + 32'(quo);
        end
        if (i_cmd.exp_fin_mul) r_fin <= 44'(sum) * 44'(i_cfg.top_speed);
        if (i_cmd.exp_fin) begin
            if (r_big) begin
                r_speed <= '0;
            end else if (((r_fin + (44'd1 << (29 + 32'(r_n)))) >> (30 + 32'(r_n))) > 44'd4095) begin
                r_speed <= 12'd4095;
            end else begin
                r_speed <= 12'((r_fin + (44'd1 << (29 + 32'(r_n)))) >> (30 + 32'(r_n)));
            end
        end
    end

    assign o_res.advance_speed = i_cmd.arrive ? 12'd0 : r_speed;
    assign o_res.turn_rate     = i_cmd.arrive ? 16'd0 :
                                 (r_b < 0 ? 16'd0 - 16'(r_tm) : 16'(r_tm));
    assign o_res.arrived       = i_cmd.arrive;
endmodule

// ----- hw/rtl/go_to_goal_drive_controller.sv -----
// top level: go-to-goal drive controller
//
// channel   dir  payload
// in_ch     in   new_goal, goal_x, goal_y, robot_x, robot_y, robot_heading
// out_ch    out  advance_speed, turn_rate, arrived
// cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data
//
// an item with no active goal goes from idle through the check state back to idle;
// an arrival also passes the distance and test states; a steering item is bounded by
// the cordic steps, up to 13 reduction steps and a term and divide state per series term
// reset is synchronous, clears the goal and output valid and sets the config to defaults
// a result sits in an output register; the next item is taken while it waits
// a full output register not being read holds the controller at its result state
module go_to_goal_drive_controller #(
    parameter int CordicSteps = gtg_pkg::CordicStepsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    gtg_if.sink         in_ch,
    gtg_if.source       out_ch
);
    import gtg_pkg::*;

    t_cfg      r_cfg;
    t_cmd      cmd;
    t_sts      sts;
    t_out_item res;
    t_in_item  item;
    logic      res_valid;
    logic      r_out_valid;
    t_out_item r_out;
    logic      out_free;

    assign item     = in_ch.data;
    assign out_free = !r_out_valid || out_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arrival_radius <= 16'd100;
            r_cfg.angle_deadband <= 15'd521;
            r_cfg.turn_gain      <= 8'd160;
            r_cfg.max_turn_rate  <= 15'd15360;
            r_cfg.top_speed      <= 12'd1000;
            r_cfg.speed_decay    <= 12'd1030;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ARRIVAL_RADIUS: r_cfg.arrival_radius <= i_cfg_data;
                CFG_ANGLE_DEADBAND: r_cfg.angle_deadband <= i_cfg_data[14:0];
                CFG_TURN_GAIN:      r_cfg.turn_gain      <= i_cfg_data[7:0];
                CFG_MAX_TURN_RATE:  r_cfg.max_turn_rate  <= i_cfg_data[14:0];
                CFG_MAX_ADV_SPEED:  r_cfg.top_speed      <= i_cfg_data[11:0];
                CFG_SPEED_DECAY:    r_cfg.speed_decay    <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    gtg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_res_valid (res_valid),
        .i_out_free  (out_free),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    gtg_dp #(.CordicSteps(CordicSteps)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_item  (item),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) r_out <= res;
    end

    assign out_ch.valid = r_out_valid;
    assign out_ch.data  = r_out;
endmodule

// ----- sim/testbench.sv -----
// testbench for the go-to-goal drive controller: random and directed items checked against a predictor
module testbench;
    import gtg_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int InW = $bits(t_in_item);
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = CFG_ARRIVAL_RADIUS;
    logic [15:0] i_cfg_data = '0;

    gtg_if #(.Width($bits(t_in_item))) in_ch ();
    gtg_if #(.Width($bits(t_out_item))) out_ch ();

    go_to_goal_drive_controller u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [15:0] m_radius;
    logic [14:0] m_deadband;
    logic [7:0]  m_gain;
    logic [14:0] m_max_turn;
    logic [11:0] m_max_speed;
    logic [11:0] m_decay;
    logic [15:0] m_goal_x, m_goal_y;
    logic        m_active;

    t_in_item  pending_items[$];
    t_out_item expected_cmds[$];
    int errors = 0;
    int cycles = 0;
    bit quiet = 0;
    bit in_taken = 0;

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] goal_angle(longint x, longint y);
        logic [31:0] z;
        longint xs, ys;
        z = 0;
        if (x < 0) begin
            x = -x; y = -y; z = 32'h80000000;
        end
        for (int i = 0; i < CordicStepsDef; i++) begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_entry(i[4:0]);
            end else begin
                x -= ys; y += xs; z -= atan_entry(i[4:0]);
            end
        end
        return z;
    endfunction

    function automatic logic [11:0] speed_for(longint unsigned mag);
        longint unsigned x30, n, r, term, pos, neg, sum, v;
        x30 = (mag * m_decay) << 12;
        n = x30 / Ln2Q30;
        r = x30 - n * Ln2Q30;
        term = OneQ30; pos = OneQ30; neg = 0;
        if (n >= 13) return 12'd0;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * r) >> 30) / k;
            if (k % 2 == 1) neg += term;
            else pos += term;
        end
        sum = (pos > neg) ? pos - neg : 0;
        v = (m_max_speed * sum + (64'd1 << (29 + n))) >> (30 + n);
        return (v > 4095) ? 12'd4095 : v[11:0];
    endfunction

    task automatic predict_command(input t_in_item it);
        longint dx, dy;
        longint unsigned d2, r2, mag, prod, tm;
        logic [31:0] phi;
        logic [15:0] hadj, b16;
        t_out_item o;
        if (it.new_goal) begin
            m_goal_x = it.goal_x; m_goal_y = it.goal_y; m_active = 1'b1;
        end
        if (!m_active) return;
        dx = longint'($signed(m_goal_x)) - longint'($signed(it.robot_x));
        dy = longint'($signed(m_goal_y)) - longint'($signed(it.robot_y));
        d2 = dx * dx + dy * dy;
        r2 = longint'(m_radius) * m_radius;
        if (d2 < r2) begin
            m_active = 1'b0;
            o = '{advance_speed: 12'd0, turn_rate: 16'd0, arrived: 1'b1};
            expected_cmds.push_back(o);
            return;
        end
        if (dx == 0 && dy == 0) b16 = 16'd0;
        else begin
            phi = (goal_angle(dx, dy) + 32'h8000) >> 16;
            hadj = it.robot_heading + 16'h8000;
            b16 = 16'h4000 - phi[15:0] + hadj;
        end
        mag = $signed(b16) < 0 ? 65536 - b16 : b16;
        if (mag < m_deadband) mag = 0;
        prod = m_gain * mag * PiQ29;
        tm = (prod + (64'd1 << 37)) >> 38;
        if (tm > m_max_turn) tm = m_max_turn;
        o.advance_speed = speed_for(tm);
        o.turn_rate = $signed(b16) < 0 ? 16'(65536 - tm) : tm[15:0];
        o.arrived = 1'b0;
        expected_cmds.push_back(o);
    endtask

    // driver
    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_ch.valid || in_taken) begin
                if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 21)) begin
                    in_ch.data <= pending_items.pop_front();
                    in_ch.valid <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
            out_ch.ready <= quiet || ($urandom_range(99) >= 21);
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_out_item got, want;
        cycles <= cycles + 1;
        in_taken = i_rst_n && in_ch.valid && in_ch.ready;
        if (in_taken) predict_command(t_in_item'(in_ch.data));
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = t_out_item'(out_ch.data);
            if (expected_cmds.size() == 0) begin
                $display("%0t unexpected result: actual %p", $time, got);
                errors++;
            end else begin
                want = expected_cmds.pop_front();
                if (got.advance_speed !== want.advance_speed)
                    $display("%0t advance_speed expected %0d actual %0d", $time,
                             want.advance_speed, got.advance_speed);
                if (got.turn_rate !== want.turn_rate)
                    $display("%0t turn_rate expected %0d actual %0d", $time,
                             $signed(want.turn_rate), $signed(got.turn_rate));
                if (got.arrived !== want.arrived)
                    $display("%0t arrived expected %0d actual %0d", $time,
                             want.arrived, got.arrived);
                if (got !== want) errors++;
            end
        end
        if (cycles > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_in_item pose(logic ng, logic [15:0] gx, logic [15:0] gy,
                                      logic [15:0] rx, logic [15:0] ry, logic [15:0] h);
        t_in_item it;
        it = '{new_goal: ng, goal_x: gx, goal_y: gy, robot_x: rx, robot_y: ry,
               robot_heading: h};
        return it;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        it = t_in_item'(InW'({$urandom, $urandom, $urandom}));
        it.new_goal = ($urandom_range(9) == 0);
        if ($urandom_range(3) == 0) begin
            it.robot_x = m_goal_x + 16'($urandom_range(600) - 300);
            it.robot_y = m_goal_y + 16'($urandom_range(600) - 300);
        end else if ($urandom_range(2) == 0) begin
            it.robot_x = 16'($signed(it.robot_x) >>> $urandom_range(15));
            it.robot_y = 16'($signed(it.robot_y) >>> $urandom_range(15));
        end
        return it;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ARRIVAL_RADIUS: m_radius = val;
            CFG_ANGLE_DEADBAND: m_deadband = val[14:0];
            CFG_TURN_GAIN:      m_gain = val[7:0];
            CFG_MAX_TURN_RATE:  m_max_turn = val[14:0];
            CFG_MAX_ADV_SPEED:  m_max_speed = val[11:0];
            CFG_SPEED_DECAY:    m_decay = val[11:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || in_ch.valid || expected_cmds.size() > 0)
            @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    initial begin
        m_radius = 100; m_deadband = 521; m_gain = 160; m_max_turn = 15360;
        m_max_speed = 1000; m_decay = 1030;
        m_goal_x = 0; m_goal_y = 0; m_active = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed items at reset settings
        pending_items.push_back(pose(0, 0, 0, 0, 0, 0));
        pending_items.push_back(pose(1, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF));
        pending_items.push_back(pose(0, 0, 0, 16'h8000, 16'h7FFF, 16'h8000));
        pending_items.push_back(pose(1, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF));
        pending_items.push_back(pose(0, 0, 0, 16'h8000, 16'h8000, 0));
        pending_items.push_back(pose(1, 50, 60, 50, 60, 0));
        pending_items.push_back(pose(1, 0, 1000, 0, 0, 0));
        pending_items.push_back(pose(0, 0, 0, 0, 0, 16'h4000));
        pending_items.push_back(pose(0, 0, 0, 0, 0, 16'hC000));
        pending_items.push_back(pose(0, 0, 0, 0, 2000, 0));
        pending_items.push_back(pose(0, 0, 0, 0, 950, 0));
        pending_items.push_back(pose(0, 0, 0, 0, 0, 0));
        pending_items.push_back(pose(1, 1000, 0, 0, 0, 16'h8000));
        drain();

        // extremes: zero radius, zero deadband, full gain
        write_reg(CFG_ARRIVAL_RADIUS, 16'd0);
        write_reg(CFG_ANGLE_DEADBAND, 16'd0);
        write_reg(CFG_TURN_GAIN, 16'd255);
        write_reg(CFG_MAX_TURN_RATE, 16'h7FFF);
        write_reg(CFG_MAX_ADV_SPEED, 16'hFFFF);
        write_reg(CFG_SPEED_DECAY, 16'd0);
        write_reg(CFG_UNUSED, 16'hFFFF);
        pending_items.push_back(pose(1, 5, 5, 5, 5, 0));
        pending_items.push_back(pose(0, 0, 0, 5, 6, 16'h1234));
        pending_items.push_back(pose(1, 10, 0, 0, 0, 16'h8000));
        pending_items.push_back(pose(0, 0, 0, 0, 0, 16'h0001));
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            quiet = (phase == 2);
            if (phase == 1) begin
                write_reg(CFG_ARRIVAL_RADIUS, 16'hFFFF);
                write_reg(CFG_ANGLE_DEADBAND, 16'h7FFF);
                write_reg(CFG_TURN_GAIN, 16'd0);
                write_reg(CFG_MAX_TURN_RATE, 16'd0);
                write_reg(CFG_MAX_ADV_SPEED, 16'd0);
                write_reg(CFG_SPEED_DECAY, 16'hFFF);
            end else if (phase > 1) begin
                write_reg(CFG_ARRIVAL_RADIUS, 16'($urandom_range(400)));
                write_reg(CFG_ANGLE_DEADBAND, 16'($urandom_range(2000)));
                write_reg(CFG_TURN_GAIN, 16'($urandom));
                write_reg(CFG_MAX_TURN_RATE, 16'($urandom));
                write_reg(CFG_MAX_ADV_SPEED, 16'($urandom));
                write_reg(CFG_SPEED_DECAY, 16'($urandom_range(4095) >> $urandom_range(11)));
            end
            for (int n = 0; n < 280; n++) pending_items.push_back(random_item());
            drain();
        end

        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
